>>> hdl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths and types for the running sample statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int COUNT_BITS  = 24;
	localparam int SUM_BITS    = 56;
	// The sum of the two running sums needs one more bit.
	localparam int TOTAL_BITS  = SUM_BITS + 1;
	// The mean never exceeds the sample range, so the quotient has sample width.
	localparam int QUOT_BITS   = SAMPLE_BITS;
	localparam int ITER_BITS   = $clog2(QUOT_BITS);

	typedef struct packed {
		logic update;
		logic total;
	} acc_ctrl_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] max_val;
		logic signed [SAMPLE_BITS-1:0] min_val;
		logic        [COUNT_BITS-1:0]  count;
		logic        [COUNT_BITS-1:0]  pos;
		logic        [COUNT_BITS-1:0]  neg;
		logic signed [SUM_BITS-1:0]    odd;
		logic signed [SUM_BITS-1:0]    even;
		logic signed [TOTAL_BITS-1:0]  total;
		logic                          match;
		logic                          dropped;
	} stats_t;

endpackage

`default_nettype wire

>>> hdl/running_sample_statistics.sv
// ----------------------------------------------------------------------------
// running_sample_statistics
// Running max, min, mean, sign counts and odd/even sums over a sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (sample, in_valid, in_ready) takes one signed sample per
//   transaction. The output channel (out_valid, out_ready) returns one result
//   transaction per sample with the statistics after that sample, its mean
//   (total sum over count, truncated toward zero) and two flags.
//   The block works on one sample at a time. A sample passes the statistics
//   update and the forming of the total, then the divider (capture, magnitude,
//   32 quotient bits, sign fix); its done flag is registered and then the
//   output register is loaded. No new sample is taken until the previous
//   sample's result has been loaded into the output register.
//   in_ready is high only while no sample is in work. A finished result sits
//   in the output register; a stalled receiver does not block the next sample,
//   but that sample's result waits until the previous one has been taken.
//   Once the count saturates, samples leave the statistics unchanged and
//   their results carry sample_dropped.
//   Reset clears every statistic to zero and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [31:0] sample,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic signed [31:0]      max_value,
	output logic signed [31:0]      min_value,
	output logic signed [31:0]      mean_value,
	output logic        [23:0]      positive_count,
	output logic        [23:0]      negative_count,
	output logic signed [55:0]      odd_total,
	output logic signed [55:0]      even_total,
	output logic                    matches_first,
	output logic                    sample_dropped,
	output logic                    out_valid,
	input  wire logic               out_ready
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_UPDATE = 5'b00010,
		S_TOTAL  = 5'b00100,
		S_DIVIDE = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t                                 state_q;
	logic                                   launch_q;
	logic                                   out_valid_q;
	logic signed [rss_pkg::SAMPLE_BITS-1:0] sample_q;

	rss_pkg::acc_ctrl_t                     acc_ctrl;
	rss_pkg::stats_t                        stats;
	logic                                   div_done;
	logic signed [rss_pkg::QUOT_BITS-1:0]   quotient;
	logic                                   in_fire;
	logic                                   load;

	assign in_ready        = (state_q == S_IDLE);
	assign in_fire         = in_valid && in_ready;
	assign load            = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign acc_ctrl.update = (state_q == S_UPDATE);
	assign acc_ctrl.total  = (state_q == S_TOTAL);

	rss_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.sample (sample_q),
		.stats  (stats)
	);

	rss_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (launch_q),
		.dividend (stats.total),
		.divisor  (stats.count),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (in_fire) state_q <= S_UPDATE;
				S_UPDATE: state_q <= S_TOTAL;
				S_TOTAL: begin
					// The total is registered at this edge; the divider
					// picks it up on the following one.
					launch_q <= 1'b1;
					state_q  <= S_DIVIDE;
				end
				S_DIVIDE: if (div_done) state_q <= S_DONE;
				S_DONE:   if (load) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) sample_q <= sample;
		if (load) begin
			max_value      <= stats.max_val;
			min_value      <= stats.min_val;
			mean_value     <= quotient;
			positive_count <= stats.pos;
			negative_count <= stats.neg;
			odd_total      <= stats.odd;
			even_total     <= stats.even;
			matches_first  <= stats.match;
			sample_dropped <= stats.dropped;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/rss_accum.sv
// ----------------------------------------------------------------------------
// rss_accum
// Running statistics registers: extremes, first sample, counts and sums.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_accum (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rss_pkg::acc_ctrl_t                  ctrl,
	input  wire logic signed [rss_pkg::SAMPLE_BITS-1:0] sample,
	output rss_pkg::stats_t                          stats
);

	localparam int SB = rss_pkg::SAMPLE_BITS;
	localparam int CB = rss_pkg::COUNT_BITS;
	localparam int MB = rss_pkg::SUM_BITS;

	logic signed [SB-1:0]                max_q, min_q, first_q;
	logic        [CB-1:0]                count_q, pos_q, neg_q;
	logic signed [MB-1:0]                odd_q, even_q;
	logic signed [rss_pkg::TOTAL_BITS-1:0] total_q;
	logic                                match_q, dropped_q;

	logic                                full;
	logic signed [MB-1:0]                sample_ext;

	assign full       = (count_q == {CB{1'b1}});
	assign sample_ext = {{(MB-SB){sample[SB-1]}}, sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= '0;
			min_q     <= '0;
			first_q   <= '0;
			count_q   <= '0;
			pos_q     <= '0;
			neg_q     <= '0;
			odd_q     <= '0;
			even_q    <= '0;
			total_q   <= '0;
			match_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (ctrl.update) begin
				dropped_q <= full;
				if (!full) begin
					// The first sample seeds both extremes.
					if (count_q == '0) begin
						max_q   <= sample;
						min_q   <= sample;
						first_q <= sample;
					end else begin
						if (sample > max_q) max_q <= sample;
						if (sample < min_q) min_q <= sample;
					end
					count_q <= count_q + 1'b1;
					if (sample > 0) pos_q <= pos_q + 1'b1;
					else if (sample < 0) neg_q <= neg_q + 1'b1;
					if (sample[0]) odd_q <= odd_q + sample_ext;
					else even_q <= even_q + sample_ext;
				end
			end
			if (ctrl.total) begin
				total_q <= {odd_q[MB-1], odd_q} + {even_q[MB-1], even_q};
				match_q <= (sample == first_q);
			end
		end
	end

	always_comb begin
		stats.max_val = max_q;
		stats.min_val = min_q;
		stats.count   = count_q;
		stats.pos     = pos_q;
		stats.neg     = neg_q;
		stats.odd     = odd_q;
		stats.even    = even_q;
		stats.total   = total_q;
		stats.match   = match_q;
		stats.dropped = dropped_q;
	end

endmodule

`default_nettype wire

>>> hdl/rss_divider.sv
// ----------------------------------------------------------------------------
// rss_divider
// Signed by unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_divider (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    start,
	input  wire logic signed [rss_pkg::TOTAL_BITS-1:0]   dividend,
	input  wire logic        [rss_pkg::COUNT_BITS-1:0]   divisor,
	output logic                                         done,
	output logic signed      [rss_pkg::QUOT_BITS-1:0]    quotient
);

	localparam int TB = rss_pkg::TOTAL_BITS;
	localparam int CB = rss_pkg::COUNT_BITS;
	localparam int QB = rss_pkg::QUOT_BITS;

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_ABS  = 4'b0010,
		D_LOOP = 4'b0100,
		D_FIX  = 4'b1000
	} div_state_t;

	div_state_t                     state_q;
	logic [TB-1:0]                  num_q;
	logic                           neg_q;
	logic [CB-1:0]                  den_q;
	logic [CB-1:0]                  rem_q;
	logic [QB-1:0]                  quo_q;
	logic [rss_pkg::ITER_BITS-1:0]  iter_q;
	logic                           done_q;
	logic signed [QB-1:0]           result_q;

	logic [TB-1:0]                  mag;
	logic [CB:0]                    shifted;
	logic [CB+1:0]                  diff;

	assign mag     = neg_q ? (~num_q + 1'b1) : num_q;
	assign shifted = {rem_q, quo_q[QB-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: if (start) state_q <= D_ABS;
				D_ABS: begin
					iter_q  <= '0;
					state_q <= D_LOOP;
				end
				D_LOOP: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == rss_pkg::ITER_BITS'(QB - 1)) state_q <= D_FIX;
				end
				D_FIX: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			num_q <= dividend;
			neg_q <= dividend[TB-1];
			den_q <= divisor;
		end
		if (state_q == D_ABS) begin
			// The quotient fits in QB bits, so the bits above them are already
			// smaller than the divisor and form the starting remainder.
			rem_q <= mag[QB +: CB];
			quo_q <= mag[QB-1:0];
		end
		if (state_q == D_LOOP) begin
			if (!diff[CB+1]) rem_q <= diff[CB-1:0];
			else rem_q <= shifted[CB-1:0];
			quo_q <= {quo_q[QB-2:0], ~diff[CB+1]};
		end
		if (state_q == D_FIX) begin
			if (den_q == '0) result_q <= '0;
			else if (neg_q) result_q <= ~quo_q + 1'b1;
			else result_q <= quo_q;
		end
	end

	assign done     = done_q;
	assign quotient = result_q;

endmodule

`default_nettype wire
